FILE: rtl/cpfs_pkg.sv
// ----------------------------------------------------------------------------
// cpfs_pkg
// Shared types, codes and helpers of the column predicate filter scan.
// ----------------------------------------------------------------------------
`default_nettype none

package cpfs_pkg;

	// comparison codes
	localparam logic [2:0] OP_GT  = 3'd0;
	localparam logic [2:0] OP_GE  = 3'd1;
	localparam logic [2:0] OP_LT  = 3'd2;
	localparam logic [2:0] OP_LE  = 3'd3;
	localparam logic [2:0] OP_NE  = 3'd4;
	localparam logic [2:0] OP_NNE = 3'd5;

	// register indexes of the config port
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_OP     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_THRESH = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FLOAT  = 2'd2;

	// largest single that is still below 1e-6
	localparam logic [31:0] NEAR_LIMIT_BITS = 32'h3586_37BD;

	localparam int ROW_INDEX_BITS_DEF = 20;
	localparam int ROW_OUT_BITS       = 20;
	localparam int FIFO_DEPTH         = 4;
	localparam int FIFO_PTR_BITS      = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] threshold;
		logic        is_float;
	} cfg_t;

	// leading zero count of a 32-bit word, 32 for zero
	function automatic logic [5:0] lzc32(input logic [31:0] x);
		logic [5:0] n;
		n = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) n = 6'(31 - i);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/column_predicate_filter_scan.sv
// ----------------------------------------------------------------------------
// column_predicate_filter_scan
// Streams a column of 32-bit words and flags each row against a threshold.
// ----------------------------------------------------------------------------
// Usage:
//   s_t* carries one column word per request, s_tlast closes a scan.
//   m_t* returns one result per word: row index, match flag, and m_tlast
//   on the last row of a scan. The row counter clears after s_tlast.
//   cfg_* writes compare_op (0), threshold_bits (1), column_is_float (2);
//   write only while no words are in flight. cfg_ready is always high.
//   Throughput: one word per cycle while m_tready stays high. A word taken
//   with all stages empty passes two front stages for integer to single
//   conversion, the queue, the compare stage and the output register.
//   When m_tready is low the output register holds, the compare stage and a
//   4-entry queue fill, and s_tready drops once the front stages are full.
//   Reset clears the valid flags, the config registers, the row counter and the queue; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module column_predicate_filter_scan #(
	parameter int ROW_INDEX_BITS = cpfs_pkg::ROW_INDEX_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [31:0]                         s_tdata,   // column_word
	input  wire                                s_tlast,   // last_row
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [23:0]                        m_tdata,   // row_index, matched, zero pad
	output logic                               m_tlast,   // scan_end
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [cpfs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire [31:0]                         cfg_data
);
	import cpfs_pkg::*;

	localparam int W = ROW_INDEX_BITS + 33;

	cfg_t                    cfg_q;
	logic [ROW_INDEX_BITS-1:0] row_q;
	logic                    push_valid, push_ready, pop_valid, pop_ready;
	logic [W-1:0]            push_data, pop_data;
	logic [ROW_INDEX_BITS-1:0] out_row;
	logic                    out_match;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OP:     cfg_q.op        <= cfg_data[2:0];
				CFG_THRESH: cfg_q.threshold <= cfg_data;
				CFG_FLOAT:  cfg_q.is_float  <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (s_tvalid && s_tready) begin
			row_q <= s_tlast ? '0 : row_q + ROW_INDEX_BITS'(1);
		end
	end

	cpfs_front #(.RB(ROW_INDEX_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_word    (s_tdata),
		.in_last    (s_tlast),
		.in_row     (row_q),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	cpfs_fifo #(.W(W)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	cpfs_back #(.RB(ROW_INDEX_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.cfg        (cfg_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_row    (out_row),
		.out_match  (out_match),
		.out_last   (m_tlast)
	);

	assign m_tdata = {3'b000, out_match, ROW_OUT_BITS'(out_row)};

	// row counter restarts after the last row of a scan
	a_row_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> row_q == '0)
		else $error("row counter not cleared after last row");

	// row counter steps by one on every accepted word that is not the last
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> row_q == $past(row_q) + ROW_INDEX_BITS'(1))
		else $error("row counter did not advance");

endmodule

`default_nettype wire

FILE: rtl/cpfs_front.sv
// ----------------------------------------------------------------------------
// cpfs_front
// Takes column words, converts integer words to single precision with round
// to nearest even, and pushes the operand with its row tag into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfs_front #(
	parameter int RB = cpfs_pkg::ROW_INDEX_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire [31:0]       in_word,
	input  wire              in_last,
	input  wire [RB-1:0]     in_row,
	input  cpfs_pkg::cfg_t   cfg,
	output logic             push_valid,
	input  wire              push_ready,
	output logic [RB+32:0]   push_data
);
	import cpfs_pkg::*;

	logic          v_s1, v_s2;
	logic [31:0]   mag_s1;
	logic          sign_s1, flt_s1, last_s1;
	logic [RB-1:0] row_s1;
	logic [31:0]   sh_s2;
	logic [7:0]    e_s2;
	logic          zero_s2, sign_s2, flt_s2, last_s2;
	logic [RB-1:0] row_s2;
	logic          en_s1, en_s2;
	logic [5:0]    lz;
	logic          rnd;
	logic [30:0]   body;
	logic [31:0]   a_bits;

	// stage enables
	assign en_s2    = !v_s2 || push_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// s1: magnitude of the integer word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mag_s1  <= (cfg.is_float || !in_word[31]) ? in_word : (~in_word + 32'd1);
			sign_s1 <= in_word[31];
			flt_s1  <= cfg.is_float;
			last_s1 <= in_last;
			row_s1  <= in_row;
		end
	end

	// s2: normalize the magnitude
	assign lz = lzc32(mag_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sh_s2   <= flt_s1 ? mag_s1 : (mag_s1 << lz[4:0]);
			e_s2    <= 8'd158 - {2'b00, lz};
			zero_s2 <= lz[5];
			sign_s2 <= sign_s1;
			flt_s2  <= flt_s1;
			last_s2 <= last_s1;
			row_s2  <= row_s1;
		end
	end

	// round to nearest even into the single format
	assign rnd  = sh_s2[7] && (|sh_s2[6:0] || sh_s2[8]);
	assign body = {e_s2, sh_s2[30:8]} + {30'd0, rnd};

	always_comb begin
		if (flt_s2) begin
			a_bits = sh_s2;
		end else if (zero_s2) begin
			a_bits = 32'd0;
		end else begin
			a_bits = {sign_s2, body};
		end
	end

	assign push_valid = v_s2;
	assign push_data  = {last_s2, row_s2, a_bits};

endmodule

`default_nettype wire

FILE: rtl/cpfs_fifo.sv
// ----------------------------------------------------------------------------
// cpfs_fifo
// Short queue between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfs_fifo #(
	parameter int W = 53
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push_valid,
	output logic         push_ready,
	input  wire [W-1:0]  push_data,
	output logic         pop_valid,
	input  wire          pop_ready,
	output logic [W-1:0] pop_data
);
	import cpfs_pkg::*;

	logic [W-1:0]             mem [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_q, rd_q;
	logic [FIFO_PTR_BITS:0]   cnt_q;
	logic                     do_push, do_pop;

	assign push_ready = (cnt_q != (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + FIFO_PTR_BITS'(1);
			if (do_pop) rd_q <= rd_q + FIFO_PTR_BITS'(1);
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (FIFO_PTR_BITS+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (FIFO_PTR_BITS+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/cpfs_back.sv
// ----------------------------------------------------------------------------
// cpfs_back
// Evaluates the predicate: ordered compare, or rounded difference magnitude
// against the near limit, and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfs_back #(
	parameter int RB = cpfs_pkg::ROW_INDEX_BITS_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            pop_valid,
	output logic           pop_ready,
	input  wire [RB+32:0]  pop_data,
	input  cpfs_pkg::cfg_t cfg,
	output logic           out_valid,
	input  wire            out_ready,
	output logic [RB-1:0]  out_row,
	output logic           out_match,
	output logic           out_last
);
	import cpfs_pkg::*;

	logic [31:0]   a, b;
	logic [30:0]   amag, bmag, xmag, ymag;
	logic          a_nan, b_nan, any_nan, both_zero;
	logic signed [31:0] ka, kb;
	logic          gt, lt, eq, ord_hit;
	logic          swap, eff_sub, x_inf, y_inf;
	logic [7:0]    e_x, e_y, d;
	logic [23:0]   mx, my;
	logic [26:0]   ymx, al, lost_mask;
	logic          sticky;
	logic [27:0]   sum;
	logic          en_b1, en_b2;

	logic          v_b1, ord_s1, nan_s1, inf_s1, last_s1;
	logic [2:0]    op_s1;
	logic [27:0]   sum_s1;
	logic [7:0]    e_s1;
	logic [RB-1:0] row_s1;

	logic [5:0]    lz;
	logic [7:0]    shamt;
	logic [26:0]   m;
	logic [8:0]    e9, ef;
	logic          rnd, under_lim, hit;
	logic [31:0]   res;

	assign en_b2     = !out_valid || out_ready;
	assign en_b1     = !v_b1 || en_b2;
	assign pop_ready = en_b1;

	// operand decode
	assign a         = pop_data[31:0];
	assign b         = cfg.threshold;
	assign amag      = a[30:0];
	assign bmag      = b[30:0];
	assign a_nan     = (&a[30:23]) && (|a[22:0]);
	assign b_nan     = (&b[30:23]) && (|b[22:0]);
	assign any_nan   = a_nan || b_nan;
	assign both_zero = (amag == '0) && (bmag == '0);

	// ordered compare on sign-magnitude keys
	assign ka = a[31] ? -$signed({1'b0, amag}) : $signed({1'b0, amag});
	assign kb = b[31] ? -$signed({1'b0, bmag}) : $signed({1'b0, bmag});
	assign eq = !any_nan && (both_zero || a == b);
	assign gt = !any_nan && !both_zero && (ka > kb);
	assign lt = !any_nan && !both_zero && (ka < kb);

	always_comb begin
		case (cfg.op)
			OP_GT:   ord_hit = gt;
			OP_GE:   ord_hit = gt || eq;
			OP_LT:   ord_hit = lt;
			OP_LE:   ord_hit = lt || eq;
			default: ord_hit = 1'b0;
		endcase
	end

	// difference: order magnitudes and align the smaller one
	assign swap    = bmag > amag;
	assign xmag    = swap ? bmag : amag;
	assign ymag    = swap ? amag : bmag;
	assign eff_sub = (a[31] == b[31]);
	assign x_inf   = (xmag == 31'h7F80_0000);
	assign y_inf   = (ymag == 31'h7F80_0000);
	assign mx      = {xmag[30:23] != 8'd0, xmag[22:0]};
	assign my      = {ymag[30:23] != 8'd0, ymag[22:0]};
	assign e_x     = (xmag[30:23] == 8'd0) ? 8'd1 : xmag[30:23];
	assign e_y     = (ymag[30:23] == 8'd0) ? 8'd1 : ymag[30:23];
	assign d       = e_x - e_y;
	assign ymx     = {my, 3'b000};

	always_comb begin
		lost_mask = ~(27'h7FF_FFFF << d[4:0]);
		if (d >= 8'd27) begin
			al     = '0;
			sticky = |my;
		end else begin
			al     = ymx >> d[4:0];
			sticky = |(ymx & lost_mask);
		end
	end

	assign sum = eff_sub ? ({1'b0, mx, 3'b000} - {1'b0, al[26:1], al[0] | sticky})
	                     : ({1'b0, mx, 3'b000} + {1'b0, al[26:1], al[0] | sticky});

	// b1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
		end else if (en_b1) begin
			v_b1 <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_b1) begin
			ord_s1  <= ord_hit;
			op_s1   <= cfg.op;
			sum_s1  <= sum;
			e_s1    <= e_x;
			nan_s1  <= any_nan || (x_inf && y_inf && eff_sub);
			inf_s1  <= x_inf;
			row_s1  <= pop_data[RB+31:32];
			last_s1 <= pop_data[RB+32];
		end
	end

	// normalize, round and test against the near limit
	assign lz = lzc32({sum_s1[26:0], 5'b11111});

	always_comb begin
		shamt = ({2'b00, lz} < (e_s1 - 8'd1)) ? {2'b00, lz} : (e_s1 - 8'd1);
		if (sum_s1[27]) begin
			m  = {sum_s1[27:2], sum_s1[1] | sum_s1[0]};
			e9 = {1'b0, e_s1} + 9'd1;
		end else begin
			m  = sum_s1[26:0] << shamt[4:0];
			e9 = {1'b0, e_s1} - {1'b0, shamt};
		end
		ef = m[26] ? e9 : 9'd0;
	end

	assign rnd       = m[2] && (m[1] || m[0] || m[3]);
	assign res       = {ef, m[25:3]} + {31'd0, rnd};
	assign under_lim = (res <= NEAR_LIMIT_BITS);

	always_comb begin
		case (op_s1)
			OP_NE:   hit = !nan_s1 && !inf_s1 && under_lim;
			OP_NNE:  hit = !nan_s1 && (inf_s1 || !under_lim);
			default: hit = ord_s1;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_b2) begin
			out_valid <= v_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_b2) begin
			out_row   <= row_s1;
			out_match <= hit;
			out_last  <= last_s1;
		end
	end

endmodule

`default_nettype wire

FILE: test/cpfs_checker.sv
// ----------------------------------------------------------------------------
// cpfs_checker
// Watches the column, result and config channels of the predicate filter
// scan, predicts each row's result from its own copy of the registers and
// the row counter, and compares every result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfs_checker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	input  wire                              s_tready,
	input  wire [31:0]                       s_tdata,   // column_word
	input  wire                              s_tlast,   // last_row
	input  wire                              m_tvalid,
	input  wire                              m_tready,
	input  wire [23:0]                       m_tdata,   // row_index, matched, zero pad
	input  wire                              m_tlast,   // scan_end
	input  wire                              cfg_valid,
	input  wire                              cfg_ready,
	input  wire [cpfs_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire [31:0]                       cfg_data,
	output int                               fail_count,
	output int                               pending
);
	import cpfs_pkg::*;

	typedef struct {
		logic [19:0] row_index;
		logic        matched;
		logic        scan_end;
	} row_result_t;

	row_result_t expected_rows[$];
	logic [2:0]  op_q;
	logic [31:0] threshold_q;
	logic        is_float_q;
	logic [19:0] row_count;

	function automatic real pow2(input int k);
		real r;
		r = 1.0;
		if (k > 0) begin
			for (int i = 0; i < k; i++) r = r * 2.0;
		end else begin
			for (int i = 0; i < -k; i++) r = r / 2.0;
		end
		return r;
	endfunction

	// value of a single bit pattern; infinities map to a huge finite value
	function automatic real single_value(input logic [31:0] b);
		real r;
		if (b[30:23] == 8'hFF) r = 1.0e300;
		else if (b[30:23] == 8'd0) r = real'(int'(b[22:0])) * pow2(-149);
		else r = real'(int'({1'b1, b[22:0]})) * pow2(int'(b[30:23]) - 150);
		return b[31] ? -r : r;
	endfunction

	// signed integer to single, round to nearest even
	function automatic real int_as_single(input logic [31:0] w);
		logic [31:0] mag, keep, rest, half;
		int p, sh;
		real r;
		if (w == 32'd0) return 0.0;
		mag = w[31] ? (~w + 32'd1) : w;
		p = 31;
		while (!mag[p]) p--;
		if (p <= 23) begin
			r = real'(int'(mag));
		end else begin
			sh = p - 23;
			keep = mag >> sh;
			rest = mag & ((32'd1 << sh) - 32'd1);
			half = 32'd1 << (sh - 1);
			if (rest > half || (rest == half && keep[0])) keep = keep + 32'd1;
			r = real'(int'(keep)) * pow2(sh);
		end
		return w[31] ? -r : r;
	endfunction

	function automatic logic is_nan(input logic [31:0] b);
		return b[30:23] == 8'hFF && b[22:0] != 23'd0;
	endfunction

	function automatic logic is_inf(input logic [31:0] b);
		return b[30:23] == 8'hFF && b[22:0] == 23'd0;
	endfunction

	function automatic logic row_hits(input logic [31:0] word);
		real a, b, d, lim, lim_next, mid;
		logic near;
		if (is_float_q && is_nan(word)) return 1'b0;
		if (is_nan(threshold_q)) return 1'b0;
		a = is_float_q ? single_value(word) : int_as_single(word);
		b = single_value(threshold_q);
		case (op_q)
			OP_GT: return a > b;
			OP_GE: return a >= b;
			OP_LT: return a < b;
			OP_LE: return a <= b;
			OP_NE, OP_NNE: begin
				// equal infinities subtract to not a number
				if (is_float_q && is_inf(word) && is_inf(threshold_q) &&
						word[31] == threshold_q[31])
					return 1'b0;
				d = a - b;
				if (d < 0.0) d = -d;
				// rounded difference stays below 1e-6 iff under the midpoint
				// to the next single; a tie rounds up to the even neighbor
				lim = single_value(NEAR_LIMIT_BITS);
				lim_next = single_value(NEAR_LIMIT_BITS + 32'd1);
				mid = (lim + lim_next) / 2.0;
				near = d < mid;
				return (op_q == OP_NE) ? near : !near;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// predict on each column request, compare on each result
	always @(posedge clk or negedge arst_n) begin
		row_result_t want;
		if (!arst_n) begin
			op_q <= OP_GT;
			threshold_q <= 32'd0;
			is_float_q <= 1'b0;
			row_count <= 20'd0;
			expected_rows.delete();
			pending <= 0;
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_OP:     op_q <= cfg_data[2:0];
					CFG_THRESH: threshold_q <= cfg_data;
					CFG_FLOAT:  is_float_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				want.row_index = row_count;
				want.matched = row_hits(s_tdata);
				want.scan_end = s_tlast;
				expected_rows.insert(expected_rows.size(), want);
				row_count <= s_tlast ? 20'd0 : row_count + 20'd1;
			end
			if (m_tvalid && m_tready) begin
				if (expected_rows.size() == 0) begin
					report("result with nothing expected");
				end else begin
					want = expected_rows.pop_front();
					if (m_tdata[19:0] !== want.row_index)
						report($sformatf("row_index %0d, want %0d",
							m_tdata[19:0], want.row_index));
					if (m_tdata[20] !== want.matched)
						report($sformatf("matched %b, want %b at row %0d",
							m_tdata[20], want.matched, want.row_index));
					if (m_tlast !== want.scan_end)
						report($sformatf("scan_end %b, want %b at row %0d",
							m_tlast, want.scan_end, want.row_index));
				end
			end
			pending <= expected_rows.size();
		end
	end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives column words through the predicate filter scan under a series of
// register settings, with random idle bursts on both sides; a checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import cpfs_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES = 14;
	localparam int ROWS_PER_PHASE = 96;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = CFG_OP;
	logic [31:0] cfg_data = 32'd0;
	int          fail_count;
	int          pending;
	int          quiet_cycles = 0;
	logic        calm = 1'b0;
	int          sink_stall = 0;

	logic [2:0]  phase_op[PHASES] = '{OP_GT, OP_GE, OP_LT, OP_LE, OP_NE, OP_NNE, 3'd6,
		3'd7, OP_NE, OP_NNE, OP_GE, OP_LT, OP_NE, OP_LE};
	logic [31:0] phase_thr[PHASES] = '{32'h0000_0000, 32'h447A_0000, 32'hC2C8_0000,
		32'h7F7F_FFFF, 32'h3F80_0000, 32'h447A_0000, 32'h3F80_0000, 32'h0000_0000,
		32'h7FC0_0000, 32'h7F80_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_0000,
		32'hCF00_0000};
	logic        phase_flt[PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
		1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

	logic [31:0] corner_words[20] = '{32'h3F80_0000, 32'h3F80_0001, 32'h3F7F_FFFF,
		32'h7FC0_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h0000_0001, 32'h8000_0000,
		32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h3586_37BD, 32'h3F80_0008,
		32'h3F80_0009, 32'h7FFF_FFFF, 32'h0100_0001, 32'h0100_0003, 32'h0000_03E8,
		32'h0000_03E7, 32'hFFFF_FF9C};

	column_predicate_filter_scan dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	cpfs_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	// result side backpressure in random bursts
	always @(posedge clk) begin
		if (calm) begin
			m_tready <= 1'b1;
		end else if (sink_stall > 0) begin
			sink_stall <= sink_stall - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			sink_stall <= $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles without any accepted request
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[column_predicate_filter_scan] ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// wait for the block to drain, then load a new setting
	task automatic load_setting(input logic [2:0] op, input logic [31:0] thr,
			input logic flt);
		repeat (8) @(posedge clk);
		while (pending != 0) @(posedge clk);
		write_reg(CFG_OP, {29'd0, op});
		write_reg(CFG_THRESH, thr);
		write_reg(CFG_FLOAT, {31'd0, flt});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_row(input logic [31:0] word, input logic last);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [31:0] pick_word(input logic [31:0] thr);
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom();
			3:       return thr;
			4:       return thr + 32'($urandom_range(0, 6)) - 32'd3;
			5:       return 32'($urandom_range(0, 2000)) - 32'd1000;
			6:       return corner_words[$urandom_range(0, 19)];
			7:       return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'($urandom())};
			default: return $urandom();
		endcase
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner words with a float column near 1.0, then as integers
		load_setting(OP_NE, 32'h3F80_0000, 1'b1);
		foreach (corner_words[i]) send_row(corner_words[i], i == 9);
		s_tvalid <= 1'b0;
		load_setting(OP_GE, 32'h4B80_0000, 1'b0);
		foreach (corner_words[i]) send_row(corner_words[i], i == 19);
		s_tvalid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			load_setting(phase_op[p], phase_thr[p], phase_flt[p]);
			if (p == PHASES - 1) calm = 1'b1;
			for (int n = 0; n < ROWS_PER_PHASE; n++)
				send_row(pick_word(phase_thr[p]), $urandom_range(0, 19) == 0);
			s_tvalid <= 1'b0;
		end

		// one random threshold, less than, on random float words
		load_setting(OP_LT, $urandom(), 1'b1);
		for (int n = 0; n < 40; n++) send_row($urandom(), n == 39);
		s_tvalid <= 1'b0;

		repeat (10) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("[column_predicate_filter_scan] OK");
		else
			$display("[column_predicate_filter_scan] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
